### rtl/fcfla_pkg.sv
// ----------------------------------------------------------------------------
// fcfla_pkg
// shared constants and codes for the fixed chunk free list allocator
// ----------------------------------------------------------------------------
package fcfla_pkg;

   localparam int MAX_BLOCKS           = 16;
   localparam int MAX_CHUNKS_PER_BLOCK = 256;
   localparam int HEADER_BYTES         = 8;

   localparam int INDEX_W      = 12;
   localparam int LINK_W       = INDEX_W + 1;
   localparam int LINK_DEPTH   = 1 << INDEX_W;
   localparam int BLOCK_CNT_W  = 5;
   localparam int CPB_W        = 9;
   localparam int CBYTES_W     = 16;
   localparam int OFFSET_W     = 28;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(1) << INDEX_W;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CHUNKS_PER_BLOCK = 2'd0,
      CSR_CHUNK_BYTES      = 2'd1,
      CSR_ALLOW_RESIZE     = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

endpackage

### rtl/fixed_chunk_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator
// fixed-size chunk pool kept as a lifo free list of chunk indices in a link ram
// ----------------------------------------------------------------------------
// free and failed allocate answer in the cycle after start; allocate from a
//   non-empty list reads the link ram, then registers the granted index and
//   offset in ST_POP; busy stays high until the item is done, so no new item is taken
// growth of the pool adds one ram write per new chunk, then ST_ISSUE, before the pop
// reset is synchronous; the link ram is not cleared, list starts empty
// results are strobed on rsp_valid for one cycle; the receiver cannot stall
module fixed_chunk_free_list_allocator (
   input  logic                                clock,
   input  logic                                reset,
   // command side
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [fcfla_pkg::INDEX_W-1:0]       req_chunk_index,
   input  logic                                req_null_handle,
   // result side
   output logic                                rsp_valid,
   output logic                                rsp_ok,
   output logic [fcfla_pkg::INDEX_W-1:0]       rsp_granted_index,
   output logic [fcfla_pkg::OFFSET_W-1:0]      rsp_data_offset,
   // configuration
   input  logic                                csr_we,
   input  logic [fcfla_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [fcfla_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fcfla_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GROW,
      ST_ISSUE,
      ST_POP
   } state_type;

   localparam int PROD_W = INDEX_W + CBYTES_W + 1;

   state_type                 state_ff;
   logic [LINK_W-1:0]         head_ff;
   logic [BLOCK_CNT_W-1:0]    blocks_ff;
   logic [CPB_W-1:0]          cpb_ff;
   logic [CBYTES_W-1:0]       chunk_bytes_ff;
   logic                      allow_resize_ff;

   // growth sweep
   logic [INDEX_W-1:0]        grow_base_ff;
   logic [CPB_W-1:0]          grow_count_ff;
   logic [CPB_W-1:0]          grow_cnt_ff;

   // result registers
   logic                      rsp_valid_ff;
   logic                      rsp_ok_ff;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic [OFFSET_W-1:0]       rsp_offset_ff;

   // link ram
   logic [LINK_W-1:0]         link_mem [LINK_DEPTH];
   logic [LINK_W-1:0]         rdata_ff;
   logic                      mem_we;
   logic [INDEX_W-1:0]        mem_waddr;
   logic [LINK_W-1:0]         mem_wdata;
   logic                      mem_re;
   logic [INDEX_W-1:0]        mem_raddr;

   logic                      accept;
   logic                      grow_ok;
   logic                      grow_last;
   logic [CPB_W-1:0]          grow_count_in;
   logic [CPB_W-1:0]          grow_cnt_inc;
   logic [INDEX_W-1:0]        grow_addr;
   logic [PROD_W-1:0]         prod;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // pool may grow only when allowed, below the block limit, with a nonzero block
   assign grow_ok = allow_resize_ff && (cpb_ff != '0)
                    && (blocks_ff < BLOCK_CNT_W'(MAX_BLOCKS));

   assign grow_count_in = (cpb_ff > CPB_W'(MAX_CHUNKS_PER_BLOCK))
                          ? CPB_W'(MAX_CHUNKS_PER_BLOCK) : cpb_ff;

   assign grow_cnt_inc = grow_cnt_ff + CPB_W'(1);
   assign grow_last    = (grow_cnt_inc == grow_count_ff);
   assign grow_addr    = grow_base_ff + INDEX_W'(grow_cnt_ff);

   // start of the chunk now at the head; its data offset adds HEADER_BYTES
   assign prod = PROD_W'(head_ff[INDEX_W-1:0])
                 * PROD_W'({1'b0, chunk_bytes_ff} + (CBYTES_W+1)'(HEADER_BYTES));

   // ram port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = req_chunk_index;
      mem_wdata = head_ff;
      mem_re    = 1'b0;
      mem_raddr = head_ff[INDEX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_FREE) && !req_null_handle) begin
               mem_we = 1'b1;
            end
            if (accept && (req_command == CMD_ALLOC) && !head_ff[INDEX_W]) begin
               mem_re = 1'b1;
            end
         end
         ST_GROW: begin
            // new block is linked in ascending order, last chunk ends the list
            mem_we    = 1'b1;
            mem_waddr = grow_addr;
            mem_wdata = grow_last ? LINK_NULL : {1'b0, grow_addr + INDEX_W'(1)};
         end
         ST_ISSUE: begin
            mem_re = 1'b1;
         end
         ST_POP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= link_mem[mem_raddr];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cpb_ff          <= '0;
         chunk_bytes_ff  <= '0;
         allow_resize_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CHUNKS_PER_BLOCK: cpb_ff          <= csr_wdata[CPB_W-1:0];
            CSR_CHUNK_BYTES:      chunk_bytes_ff  <= csr_wdata[CBYTES_W-1:0];
            CSR_ALLOW_RESIZE:     allow_resize_ff <= csr_wdata[0];
            default: begin
               // unknown register, write dropped
            end
         endcase
      end
   end

   // sequencer, list head and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= LINK_NULL;
         blocks_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_command == CMD_FREE) begin
                     if (!req_null_handle) begin
                        head_ff <= {1'b0, req_chunk_index};
                     end
                     rsp_valid_ff  <= 1'b1;
                     rsp_ok_ff     <= 1'b1;
                     rsp_index_ff  <= '0;
                     rsp_offset_ff <= '0;
                  end else if (!head_ff[INDEX_W]) begin
                     // link of the head is on its way out of the ram
                     state_ff <= ST_POP;
                  end else if (grow_ok) begin
                     state_ff      <= ST_GROW;
                     grow_base_ff  <= INDEX_W'(blocks_ff * BLOCK_CNT_W'(0)
                                      + INDEX_W'(blocks_ff) * INDEX_W'(MAX_CHUNKS_PER_BLOCK));
                     grow_count_ff <= grow_count_in;
                     grow_cnt_ff   <= '0;
                  end else begin
                     // empty list and no growth: failed allocate
                     rsp_valid_ff  <= 1'b1;
                     rsp_ok_ff     <= 1'b0;
                     rsp_index_ff  <= '0;
                     rsp_offset_ff <= '0;
                  end
               end
            end
            ST_GROW: begin
               grow_cnt_ff <= grow_cnt_inc;
               if (grow_last) begin
                  head_ff   <= {1'b0, grow_base_ff};
                  blocks_ff <= blocks_ff + BLOCK_CNT_W'(1);
                  state_ff  <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_POP;
            end
            ST_POP: begin
               // pop: next link becomes the head, old head is granted
               head_ff       <= rdata_ff;
               rsp_valid_ff  <= 1'b1;
               rsp_ok_ff     <= 1'b1;
               rsp_index_ff  <= head_ff[INDEX_W-1:0];
               rsp_offset_ff <= OFFSET_W'(prod + PROD_W'(HEADER_BYTES));
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_granted_index = rsp_index_ff;
   assign rsp_data_offset   = rsp_offset_ff;

`ifndef ASSERT_OFF
   // a failed allocate never carries an index or offset
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_granted_index == '0 && rsp_data_offset == '0))
      else $error("failed allocate carries payload");

   // block count never passes the limit
   assert property (@(posedge clock) disable iff (reset)
      blocks_ff <= BLOCK_CNT_W'(MAX_BLOCKS))
      else $error("block count over limit");

   // the growth sweep stays inside its block
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GROW) |-> (grow_cnt_ff < grow_count_ff))
      else $error("growth sweep overran");

   // a real free makes the freed chunk the new head
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_FREE && !req_null_handle)
      |=> (head_ff == {1'b0, $past(req_chunk_index)}))
      else $error("freed chunk not at head");

   // a pop only happens with a valid head
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> !head_ff[INDEX_W])
      else $error("pop from empty list");
`endif

endmodule

### tb/sv/fixed_chunk_free_list_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator_tb
// self-checking bench for the chunk pool: a clocked driver feeds allocate and
// free items from a backlog, a shadow pool predicts every result at the
// accept edge, a clocked monitor compares each strobed result in order
// ----------------------------------------------------------------------------
module fixed_chunk_free_list_allocator_tb;

   import fcfla_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   // the fourth register slot decodes to nothing
   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED = 2'd3;

   // one item as queued by the stimulus; from_live picks a chunk we hold at
   // drive time, hold makes the driver wait until the pool has gone quiet
   typedef struct {
      command_type           command;
      logic [INDEX_W-1:0]    chunk_index;
      logic                  null_handle;
      bit                    from_live;
      bit                    hold;
   } pool_cmd_type;

   typedef struct {
      logic                  ok;
      logic [INDEX_W-1:0]    granted_index;
      logic [OFFSET_W-1:0]   data_offset;
   } grant_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_command = CMD_ALLOC;
   logic [INDEX_W-1:0]       req_chunk_index = '0;
   logic                     req_null_handle = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ok;
   logic [INDEX_W-1:0]       rsp_granted_index;
   logic [OFFSET_W-1:0]      rsp_data_offset;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_addr = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // shadow pool: link memory, list head, grown blocks and the registers
   logic [LINK_W-1:0]        link_ram [LINK_DEPTH];
   logic [LINK_W-1:0]        free_head = LINK_NULL;
   int unsigned              blocks_in_use = 0;
   logic [CPB_W-1:0]         cfg_chunks_per_block = '0;
   logic [CBYTES_W-1:0]      cfg_chunk_bytes = '0;
   logic                     cfg_allow_resize = 1'b1;

   pool_cmd_type             cmd_backlog [$];
   grant_type                expected_grants [$];
   logic [INDEX_W-1:0]       held_chunks [$];
   pool_cmd_type             on_port;
   bit                       gaps_on = 1'b1;
   int unsigned              gap_left = 0;
   int unsigned              n_failures = 0;
   int unsigned              cycle_count = 0;

   fixed_chunk_free_list_allocator i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_chunk_index   (req_chunk_index),
      .req_null_handle   (req_null_handle),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_granted_index (rsp_granted_index),
      .rsp_data_offset   (rsp_data_offset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // shadow pool: applies one accepted item and queues the result it owes
   // ------------------------------------------------------------------------
   function automatic void apply_pool_command(input pool_cmd_type it);
      grant_type           res;
      logic [INDEX_W-1:0]  got;
      int unsigned         count;
      int unsigned         base;
      longint unsigned     offset;
      res = '{ok: 1'b0, granted_index: '0, data_offset: '0};
      if (it.command == CMD_FREE) begin
         // any index is pushed, a null handle leaves the list alone
         if (!it.null_handle) begin
            link_ram[it.chunk_index] = free_head;
            free_head = {1'b0, it.chunk_index};
         end
         res.ok = 1'b1;
      end else begin
         // empty list: grow by one block if allowed, linked in ascending order
         if (free_head[INDEX_W] && cfg_allow_resize && cfg_chunks_per_block != 0 &&
             blocks_in_use < MAX_BLOCKS) begin
            count = (cfg_chunks_per_block > MAX_CHUNKS_PER_BLOCK) ?
                    MAX_CHUNKS_PER_BLOCK : cfg_chunks_per_block;
            base = blocks_in_use * MAX_CHUNKS_PER_BLOCK;
            for (int unsigned k = 0; k < count; k++)
               link_ram[INDEX_W'(base + k)] = (k + 1 < count) ?
                  {1'b0, INDEX_W'(base + k + 1)} : LINK_NULL;
            free_head = {1'b0, INDEX_W'(base)};
            blocks_in_use++;
         end
         // still empty means a failed allocate with no state change
         if (!free_head[INDEX_W]) begin
            got = free_head[INDEX_W-1:0];
            free_head = link_ram[got];
            offset = longint'(got) * (longint'(cfg_chunk_bytes) + HEADER_BYTES)
                     + HEADER_BYTES;
            res.ok = 1'b1;
            res.granted_index = got;
            res.data_offset = offset[OFFSET_W-1:0];
            held_chunks.push_back(got);
         end
      end
      expected_grants.push_back(res);
   endfunction

   // ------------------------------------------------------------------------
   // driver: presents backlog items, predicts at the accept edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_items
      pool_cmd_type nxt;
      bit           present;
      int unsigned  pick;
      if (reset) begin
         start <= 1'b0;
      end else begin
         present = start;
         if (start && !busy) begin
            apply_pool_command(on_port);
            present = 1'b0;
            // random sender gap after this item
            if (gaps_on && $urandom_range(0, 2) == 0)
               gap_left = $urandom_range(1, 7);
         end
         if (!present) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].hold &&
                           (expected_grants.size() != 0 || busy))) begin
               nxt = cmd_backlog.pop_front();
               // free of a chunk we hold; allocate instead if we hold none
               if (nxt.from_live) begin
                  if (held_chunks.size() != 0) begin
                     pick = $urandom_range(0, held_chunks.size() - 1);
                     nxt.chunk_index = held_chunks[pick];
                     held_chunks.delete(pick);
                  end else begin
                     nxt.command = CMD_ALLOC;
                  end
               end
               on_port = nxt;
               req_command <= nxt.command;
               req_chunk_index <= nxt.chunk_index;
               req_null_handle <= nxt.null_handle;
               present = 1'b1;
            end
         end
         start <= present;
      end
   end

   // ------------------------------------------------------------------------
   // monitor: each strobed result against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_grants
      grant_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_grants.size() == 0) begin
            $error("unexpected result: ok %0d index %0d offset %0d",
                   rsp_ok, rsp_granted_index, rsp_data_offset);
            n_failures++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_ok);
               n_failures++;
            end
            if (rsp_granted_index !== want.granted_index) begin
               $error("granted_index: expected %0d, got %0d",
                      want.granted_index, rsp_granted_index);
               n_failures++;
            end
            if (rsp_data_offset !== want.data_offset) begin
               $error("data_offset: expected %0d, got %0d",
                      want.data_offset, rsp_data_offset);
               n_failures++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void queue_cmd(input command_type cmd,
                                     input logic [INDEX_W-1:0] idx,
                                     input logic nh, input bit live, input bit hold);
      pool_cmd_type it;
      it.command = cmd;
      it.chunk_index = idx;
      it.null_handle = nh;
      it.from_live = live;
      it.hold = hold;
      cmd_backlog.push_back(it);
   endfunction

   // mostly allocates and frees of held chunks, some null and stray frees
   function automatic void queue_mix(input int unsigned n_items,
                                     input int unsigned alloc_pct);
      int unsigned roll;
      repeat (n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < alloc_pct) begin
            // index and null flag are don't-care for an allocate
            queue_cmd(CMD_ALLOC, INDEX_W'($urandom_range(0, LINK_DEPTH - 1)),
                      1'($urandom_range(0, 1)), 1'b0, $urandom_range(0, 149) == 0);
         end else begin
            roll = $urandom_range(0, 19);
            queue_cmd(CMD_FREE, INDEX_W'($urandom_range(0, LINK_DEPTH - 1)),
                      roll < 2, roll > 2, $urandom_range(0, 149) == 0);
         end
      end
   endfunction

   // register write, shadow copy updated alongside
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_CHUNKS_PER_BLOCK: cfg_chunks_per_block = data[CPB_W-1:0];
         CSR_CHUNK_BYTES:      cfg_chunk_bytes = data[CBYTES_W-1:0];
         CSR_ALLOW_RESIZE:     cfg_allow_resize = data[0];
         default: ;
      endcase
   endtask

   // all registers plus the unmapped slot; unused upper bits get noise
   task automatic set_regs(input logic [CPB_W-1:0] cpb,
                           input logic [CBYTES_W-1:0] cbytes, input logic resize);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'($urandom);
      word[CPB_W-1:0] = cpb;
      write_reg(CSR_CHUNKS_PER_BLOCK, word);
      write_reg(CSR_CHUNK_BYTES, cbytes);
      word = CSR_DATA_W'($urandom);
      word[0] = resize;
      write_reg(CSR_ALLOW_RESIZE, word);
      write_reg(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (cmd_backlog.size() != 0 || start || busy || expected_grants.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin : run_stimulus
      int unsigned       list_len;
      logic [LINK_W-1:0] walk;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero chunks per block, so an empty list cannot grow
      queue_cmd(CMD_ALLOC, '1, 1'b1, 1'b0, 1'b0);
      queue_cmd(CMD_FREE,  '1, 1'b1, 1'b0, 1'b0);  // null handle, no-op
      queue_cmd(CMD_ALLOC, '0, 1'b0, 1'b0, 1'b0);
      queue_cmd(CMD_FREE,  '1, 1'b0, 1'b0, 1'b0);  // free of a never-allocated chunk
      queue_cmd(CMD_ALLOC, '0, 1'b0, 1'b0, 1'b0);
      queue_cmd(CMD_ALLOC, '0, 1'b0, 1'b0, 1'b0);
      wait_idle();

      // resizing off; top index with widest chunk gives the largest offset
      set_regs(CPB_W'(1), '1, 1'b0);
      queue_cmd(CMD_ALLOC, '0, 1'b0, 1'b0, 1'b0);
      queue_cmd(CMD_FREE,  '1, 1'b0, 1'b0, 1'b0);
      queue_cmd(CMD_ALLOC, '0, 1'b0, 1'b0, 1'b0);
      wait_idle();

      // one-chunk blocks: each empty allocate grows the pool
      set_regs(CPB_W'(1), '1, 1'b1);
      queue_cmd(CMD_ALLOC, '0, 1'b0, 1'b0, 1'b0);
      queue_cmd(CMD_ALLOC, '0, 1'b0, 1'b0, 1'b0);
      queue_cmd(CMD_FREE,  '0, 1'b0, 1'b1, 1'b1);  // sender waits for a quiet pool
      queue_cmd(CMD_FREE,  '0, 1'b0, 1'b1, 1'b0);
      queue_cmd(CMD_ALLOC, '0, 1'b0, 1'b0, 1'b0);
      queue_cmd(CMD_ALLOC, '0, 1'b0, 1'b0, 1'b0);
      queue_cmd(CMD_FREE,  '0, 1'b1, 1'b0, 1'b0);
      wait_idle();

      // small blocks, balanced traffic
      set_regs(CPB_W'($urandom_range(4, 8)), CBYTES_W'($urandom), 1'b1);
      queue_mix(180, 50);
      wait_idle();

      // zero-size blocks: allocates on an empty list fail
      set_regs(CPB_W'(0), '0, 1'b1);
      queue_mix(120, 55);
      wait_idle();

      // resizing off, widest chunks
      set_regs(CPB_W'($urandom_range(1, 511)), '1, 1'b0);
      queue_mix(120, 55);
      wait_idle();

      // oversized block request saturates; drain the list and the whole new
      // block so the last chunk's null link is exercised, no sender gaps
      gaps_on = 1'b0;
      set_regs(CPB_W'($urandom_range(MAX_CHUNKS_PER_BLOCK + 1, 511)),
               CBYTES_W'($urandom), 1'b1);
      list_len = 0;
      walk = free_head;
      while (!walk[INDEX_W] && list_len < LINK_DEPTH) begin
         walk = link_ram[walk[INDEX_W-1:0]];
         list_len++;
      end
      repeat (((list_len > 300) ? 300 : list_len) + MAX_CHUNKS_PER_BLOCK) begin
         queue_cmd(CMD_ALLOC, INDEX_W'($urandom_range(0, LINK_DEPTH - 1)),
                   1'($urandom_range(0, 1)), 1'b0, 1'b0);
         if ($urandom_range(0, 9) == 0)
            queue_cmd(CMD_FREE, INDEX_W'($urandom_range(0, LINK_DEPTH - 1)),
                      1'b1, 1'b0, 1'b0);
      end
      wait_idle();

      // tiny blocks under allocate pressure until the block limit is hit
      set_regs(CPB_W'($urandom_range(1, 3)), CBYTES_W'($urandom), 1'b1);
      queue_mix(300, 80);
      wait_idle();

      repeat (8) @(posedge clock);
      if (n_failures == 0 && expected_grants.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
